FILE: src/qrs_pkg.sv
`default_nettype none

package qrs_pkg;

  localparam logic [1:0] KIND_REAL  = 2'd0;
  localparam logic [1:0] KIND_CPLX  = 2'd1;
  localparam logic [1:0] KIND_DEGEN = 2'd2;

  localparam int COEF_W   = 16;
  localparam int RAD_W    = 34;   // magnitude of the discriminant, zero-extended
  localparam int ROOT_W   = 33;   // floor(sqrt(n * 2^32))
  localparam int REM_W    = 36;
  localparam int SQ_STEPS = 33;
  localparam int NUM_W    = 34;   // dividend magnitude
  localparam int DEN_W    = 17;   // |2a|
  localparam int OUT_W    = 32;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic signed [32:0] p;        // -b * 2^16
    logic               is_real;
    logic               a_zero;
    logic               a_neg;
    logic [DEN_W-1:0]   den;
  } qrs_side_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       neg0;
    logic       neg1;
  } qrs_div_side_t;

endpackage

`default_nettype wire

FILE: src/qrs_div_pipe.sv
`default_nettype none

module qrs_div_pipe #(
  parameter int NW    = 34,
  parameter int DW    = 17,
  parameter int LANES = 3,
  parameter int SW    = 4
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     vld_i,
  input  wire logic [LANES-1:0][NW-1:0] num_i,
  input  wire logic [DW-1:0]            den_i,
  input  wire logic [SW-1:0]            side_i,
  output logic                          vld_o,
  output logic [LANES-1:0][NW-1:0]      quo_o,
  output logic [SW-1:0]                 side_o
);

  // Each stage retires one quotient bit; the dividend shifts out as the
  // quotient shifts in, so after NW stages num holds the quotient.
  logic [LANES-1:0][NW-1:0] num_w  [0:NW];
  logic [LANES-1:0][DW-1:0] rem_w  [0:NW];
  logic [DW-1:0]            den_w  [0:NW];
  logic [SW-1:0]            side_w [0:NW];
  logic                     vld_w  [0:NW];

  assign num_w[0]  = num_i;
  assign rem_w[0]  = '0;
  assign den_w[0]  = den_i;
  assign side_w[0] = side_i;
  assign vld_w[0]  = vld_i;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [LANES-1:0][NW-1:0] num_d, num_q;
    logic [LANES-1:0][DW-1:0] rem_d, rem_q;
    logic [DW-1:0]            den_q;
    logic [SW-1:0]            side_q;
    logic                     vld_q;

    always_comb begin
      logic [DW:0]   r;
      logic [DW+1:0] diff;
      for (int l = 0; l < LANES; l++) begin
        r    = {rem_w[k][l], num_w[k][l][NW-1]};
        diff = {1'b0, r} - {2'b00, den_w[k]};
        if (!diff[DW+1]) begin
          rem_d[l] = diff[DW-1:0];
          num_d[l] = {num_w[k][l][NW-2:0], 1'b1};
        end else begin
          rem_d[l] = r[DW-1:0];
          num_d[l] = {num_w[k][l][NW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en_i) begin
        vld_q <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q  <= num_d;
        rem_q  <= rem_d;
        den_q  <= den_w[k];
        side_q <= side_w[k];
      end
    end

    assign num_w[k+1]  = num_q;
    assign rem_w[k+1]  = rem_q;
    assign den_w[k+1]  = den_q;
    assign side_w[k+1] = side_q;
    assign vld_w[k+1]  = vld_q;
  end

  assign vld_o  = vld_w[NW];
  assign quo_o  = num_w[NW];
  assign side_o = side_w[NW];

endmodule

`default_nettype wire

FILE: src/quadratic_root_solver_core.sv
`default_nettype none

// An accepted request passes through the product stage, the discriminant register, the square root, the prep stage,
// the divider and the output register. Throughput: one request per cycle while the output is not stalled; the 33-stage
// square root and the 34-stage divider each retire one bit per stage.
// The whole pipeline holds while a result waits on the output.
// Reset clears all valid bits; data registers are not reset.
module quadratic_root_solver_core (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [47:0]  s_axis_tdata_i,   // coef_a, coef_b, coef_c
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  output logic [127:0]      m_axis_tdata_o,   // root1_re, root1_im, root2_re, root2_im
  output logic [2:0]        m_axis_tuser_o    // root_kind, saturated
);

  localparam int SqSteps = qrs_pkg::SQ_STEPS;

  logic en;
  logic out_vld_q;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Stage 1: products.
  logic               v1_q;
  logic signed [15:0] a1_q, b1_q;
  logic signed [31:0] bb1_q, ac1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q  <= $signed(s_axis_tdata_i[15:0]);
      b1_q  <= $signed(s_axis_tdata_i[31:16]);
      bb1_q <= $signed(s_axis_tdata_i[31:16]) * $signed(s_axis_tdata_i[31:16]);
      ac1_q <= $signed(s_axis_tdata_i[15:0]) * $signed(s_axis_tdata_i[47:32]);
    end
  end

  // Stage 2: discriminant and operand preparation.
  logic signed [33:0] dn;
  logic [16:0]        a_abs;
  logic [16:0]        negb;
  qrs_pkg::qrs_side_t side_d;

  always_comb begin
    dn    = 34'(bb1_q) - (34'(ac1_q) <<< 2);
    a_abs = a1_q[15] ? (17'd0 - {a1_q[15], a1_q}) : {a1_q[15], a1_q};
    negb  = 17'd0 - {b1_q[15], b1_q};
    side_d.rad     = dn[33] ? 34'(-dn) : 34'(dn);
    side_d.p       = $signed({negb, 16'h0000});
    side_d.is_real = !dn[33];
    side_d.a_zero  = (a1_q == 16'sd0);
    side_d.a_neg   = a1_q[15];
    side_d.den     = {a_abs[15:0], 1'b0};
  end

  // Square root: one result bit per stage.
  qrs_pkg::qrs_side_t          sq_side [0:SqSteps];
  logic [qrs_pkg::REM_W-1:0]   sq_rem  [0:SqSteps];
  logic [qrs_pkg::ROOT_W-1:0]  sq_root [0:SqSteps];
  logic                        sq_vld  [0:SqSteps];
  qrs_pkg::qrs_side_t          sq_side0_q;
  logic                        sq_vld0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld0_q <= 1'b0;
    end else if (en) begin
      sq_vld0_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_side0_q <= side_d;
    end
  end

  assign sq_vld[0]  = sq_vld0_q;
  assign sq_side[0] = sq_side0_q;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
    localparam int I = SqSteps - 1 - k;
    logic [1:0]                 pair;
    logic [qrs_pkg::REM_W-1:0]  rem_s, trial, rem_d, rem_q;
    logic [qrs_pkg::ROOT_W-1:0] root_d, root_q;
    qrs_pkg::qrs_side_t         side_q;
    logic                       vld_q;

    if (2 * I >= 32) begin : g_pair
      assign pair = sq_side[k].rad[2*I-32 +: 2];
    end else begin : g_zero
      assign pair = 2'b00;
    end

    always_comb begin
      rem_s = {sq_rem[k][qrs_pkg::REM_W-3:0], pair};
      trial = {1'b0, sq_root[k], 2'b01};
      if (rem_s >= trial) begin
        rem_d  = rem_s - trial;
        root_d = {sq_root[k][qrs_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_s;
        root_d = {sq_root[k][qrs_pkg::ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= sq_vld[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        rem_q  <= rem_d;
        root_q <= root_d;
        side_q <= sq_side[k];
      end
    end

    assign sq_rem[k+1]  = rem_q;
    assign sq_root[k+1] = root_q;
    assign sq_side[k+1] = side_q;
    assign sq_vld[k+1]  = vld_q;
  end

  // Magnitude of trunc-ready dividend for (s + q), with s standing for a
  // value in [s, s+1) unless exact.
  function automatic logic [34:0] prep(input logic [32:0] s, input logic signed [32:0] q,
                                       input logic exact);
    logic signed [34:0] t;
    logic [34:0]        m;
    t = $signed({2'b00, s}) + 35'(q);
    if (!t[34]) begin
      prep = {1'b0, t[33:0]};
    end else begin
      m    = 35'(-t) - (exact ? 35'd0 : 35'd1);
      prep = {1'b1, m[33:0]};
    end
  endfunction

  // Prep stage ahead of the divider.
  qrs_pkg::qrs_side_t sq_out;
  logic [32:0]        s_root;
  logic               exact;
  logic [34:0]        pr0, pr1;
  logic [2:0][qrs_pkg::NUM_W-1:0] dv_num_d, dv_num_q;
  qrs_pkg::qrs_div_side_t dv_side_d, dv_side_q;
  logic               dv_vld_q;
  logic [qrs_pkg::DEN_W-1:0] dv_den_q;

  always_comb begin
    sq_out = sq_side[SqSteps];
    s_root = sq_root[SqSteps];
    exact  = (sq_rem[SqSteps] == '0);
    pr0 = sq_out.is_real ? prep(s_root, sq_out.p, exact) : prep(33'd0, sq_out.p, 1'b1);
    pr1 = prep(s_root, -sq_out.p, exact);
    dv_num_d[0] = pr0[33:0];
    dv_num_d[1] = pr1[33:0];
    dv_num_d[2] = {1'b0, s_root};
    dv_side_d.neg0 = pr0[34] ^ sq_out.a_neg;
    dv_side_d.neg1 = !pr1[34] ^ sq_out.a_neg;
    if (sq_out.a_zero) begin
      dv_side_d.kind = qrs_pkg::KIND_DEGEN;
    end else if (sq_out.is_real) begin
      dv_side_d.kind = qrs_pkg::KIND_REAL;
    end else begin
      dv_side_d.kind = qrs_pkg::KIND_CPLX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= 1'b0;
    end else if (en) begin
      dv_vld_q <= sq_vld[SqSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_num_q  <= dv_num_d;
      dv_side_q <= dv_side_d;
      dv_den_q  <= sq_out.den;
    end
  end

  logic                           q_vld;
  logic [2:0][qrs_pkg::NUM_W-1:0] quo;
  qrs_pkg::qrs_div_side_t         q_side;

  qrs_div_pipe #(
    .NW    (qrs_pkg::NUM_W),
    .DW    (qrs_pkg::DEN_W),
    .LANES (3),
    .SW    ($bits(qrs_pkg::qrs_div_side_t))
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dv_vld_q),
    .num_i  (dv_num_q),
    .den_i  (dv_den_q),
    .side_i (dv_side_q),
    .vld_o  (q_vld),
    .quo_o  (quo),
    .side_o (q_side)
  );

  function automatic logic [32:0] clamp(input logic [33:0] mag, input logic neg);
    if (!neg) begin
      if (mag[33:31] != 3'd0) begin
        clamp = {1'b1, 32'h7FFF_FFFF};
      end else begin
        clamp = {1'b0, mag[31:0]};
      end
    end else begin
      if (mag[33:32] != 2'd0 || (mag[31] && mag[30:0] != 31'd0)) begin
        clamp = {1'b1, 32'h8000_0000};
      end else begin
        clamp = {1'b0, 32'd0 - mag[31:0]};
      end
    end
  endfunction

  // Output stage.
  logic [32:0]  c0, c1, c2;
  logic [127:0] out_data_d, out_data_q;
  logic [2:0]   out_user_d, out_user_q;

  always_comb begin
    c0 = clamp(quo[0], q_side.neg0);
    c1 = clamp(quo[1], q_side.neg1);
    c2 = clamp(quo[2], 1'b0);
    case (q_side.kind)
      qrs_pkg::KIND_REAL: begin
        out_data_d = {32'd0, c1[31:0], 32'd0, c0[31:0]};
        out_user_d = {c0[32] | c1[32], qrs_pkg::KIND_REAL};
      end
      qrs_pkg::KIND_CPLX: begin
        out_data_d = {32'd0 - c2[31:0], c0[31:0], c2[31:0], c0[31:0]};
        out_user_d = {c0[32] | c2[32], qrs_pkg::KIND_CPLX};
      end
      default: begin
        out_data_d = '0;
        out_user_d = {1'b0, qrs_pkg::KIND_DEGEN};
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

`ifndef ASSERT_OFF
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1:0] == qrs_pkg::KIND_DEGEN)
      |-> (m_axis_tdata_o == '0 && !m_axis_tuser_o[2]))
    else $error("degenerate result carries nonzero roots");

  a_conj_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1:0] == qrs_pkg::KIND_CPLX)
      |-> (m_axis_tdata_o[95:64] == m_axis_tdata_o[31:0]
           && m_axis_tdata_o[127:96] == 32'd0 - m_axis_tdata_o[63:32]
           && !m_axis_tdata_o[63]))
    else $error("complex pair is not conjugate");

  a_real_im: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[1:0] == qrs_pkg::KIND_REAL)
      |-> (m_axis_tdata_o[63:32] == 32'd0 && m_axis_tdata_o[127:96] == 32'd0))
    else $error("real roots have imaginary parts");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(sq_root[SqSteps]))
    else $error("pipeline moved during an output stall");
`endif

endmodule

`default_nettype wire

FILE: tb/quadratic_root_solver_checker.sv
`timescale 1ns / 1ps

module quadratic_root_solver_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  input  wire logic         s_axis_tready_i,
  input  wire logic [47:0]  s_axis_tdata_i,   // coef_a, coef_b, coef_c
  input  wire logic         m_axis_tvalid_i,
  input  wire logic         m_axis_tready_i,
  input  wire logic [127:0] m_axis_tdata_i,   // root1_re, root1_im, root2_re, root2_im
  input  wire logic [2:0]   m_axis_tuser_i,   // root_kind, saturated
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic [31:0] r1re;
    logic [31:0] r1im;
    logic [31:0] r2re;
    logic [31:0] r2im;
    logic [1:0]  kind;
    logic        sat;
  } roots_t;

  roots_t roots_q[$];
  int     fails = 0;

  assign fail_count_o = fails;
  assign pending_o    = roots_q.size();

  // Floor of sqrt(n * 2^32), bit by bit; bit 0 of the result flags a remainder.
  function automatic logic [64:0] scaled_sqrt(input longint unsigned n);
    longint unsigned rem, root, pair;
    int bitpos;
    rem  = '0;
    root = '0;
    for (int i = 32; i >= 0; i--) begin
      bitpos = 2 * i;
      pair = (bitpos >= 32) ? ((n >> (bitpos - 32)) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      if (rem >= ((root << 2) | 64'd1)) begin
        rem  = rem - ((root << 2) | 64'd1);
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return {root, rem != 64'd0};
  endfunction

  // Truncated sign*(T+q)/den with T in [s, s+1); returns {saturated, value}.
  function automatic logic [32:0] trunc_quot(input longint q, input longint s,
                                             input bit exact, input bit flip,
                                             input longint den_in);
    longint unsigned mag;
    longint den;
    bit neg;
    den = den_in;
    if (q >= 0 || s >= -q) begin
      mag = s + q;
      neg = 1'b0;
    end else begin
      mag = -q - s - (exact ? 64'sd0 : 64'sd1);
      neg = 1'b1;
    end
    if (flip) neg = !neg;
    if (den < 0) begin
      neg = !neg;
      den = -den;
    end
    mag = mag / longint'(den);
    if (!neg) begin
      if (mag > 64'd2147483647) return {1'b1, 32'h7fffffff};
      return {1'b0, mag[31:0]};
    end
    if (mag > 64'd2147483648) return {1'b1, 32'h80000000};
    return {1'b0, 32'(-mag)};
  endfunction

  function automatic roots_t solve_roots(input logic [47:0] coefs);
    roots_t r;
    longint a, b, c, dn, p, den;
    logic [64:0] sq;
    logic [32:0] q1, q2;
    a = longint'($signed(coefs[15:0]));
    b = longint'($signed(coefs[31:16]));
    c = longint'($signed(coefs[47:32]));
    r = '0;
    if (a == 0) begin
      r.kind = qrs_pkg::KIND_DEGEN;
      return r;
    end
    dn  = b * b - 4 * a * c;
    p   = -b * 65536;
    den = 2 * a;
    if (dn >= 0) begin
      r.kind = qrs_pkg::KIND_REAL;
      sq = scaled_sqrt(dn);
      q1 = trunc_quot(p, sq[64:1], !sq[0], 1'b0, den);
      q2 = trunc_quot(-p, sq[64:1], !sq[0], 1'b1, den);
      r.r1re = q1[31:0];
      r.r2re = q2[31:0];
    end else begin
      r.kind = qrs_pkg::KIND_CPLX;
      sq = scaled_sqrt(-dn);
      q1 = trunc_quot(p, 64'sd0, 1'b1, 1'b0, den);
      q2 = trunc_quot(64'sd0, sq[64:1], !sq[0], 1'b0, den < 0 ? -den : den);
      r.r1re = q1[31:0];
      r.r2re = q1[31:0];
      r.r1im = q2[31:0];
      r.r2im = -q2[31:0];
    end
    r.sat = q1[32] | q2[32];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", field, got, want);
    fails++;
  endtask

  always @(posedge clk_i) begin
    roots_t got, want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_i) roots_q.push_back(solve_roots(s_axis_tdata_i));
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = {m_axis_tdata_i[31:0], m_axis_tdata_i[63:32], m_axis_tdata_i[95:64],
               m_axis_tdata_i[127:96], m_axis_tuser_i[1:0], m_axis_tuser_i[2]};
        if (roots_q.size() == 0) begin
          report_mismatch("result with no request outstanding", 32'd0, 32'd0);
        end else begin
          want = roots_q.pop_front();
          if (got.r1re != want.r1re) report_mismatch("root1_re", got.r1re, want.r1re);
          if (got.r1im != want.r1im) report_mismatch("root1_im", got.r1im, want.r1im);
          if (got.r2re != want.r2re) report_mismatch("root2_re", got.r2re, want.r2re);
          if (got.r2im != want.r2im) report_mismatch("root2_im", got.r2im, want.r2im);
          if (got.kind != want.kind) begin
            report_mismatch("root_kind", 32'(got.kind), 32'(want.kind));
          end
          if (got.sat != want.sat) begin
            report_mismatch("saturated", 32'(got.sat), 32'(want.sat));
          end
        end
      end
    end
  end

endmodule

FILE: tb/quadratic_root_solver_core_tb.sv
`timescale 1ns / 1ps

module quadratic_root_solver_core_tb;

  localparam int WATCHDOG_LIMIT = 5000;

  logic         clk;
  logic         rst_n;
  logic         s_valid;
  logic         s_ready;
  logic [47:0]  s_data;
  logic         m_valid;
  logic         m_ready;
  logic [127:0] m_data;
  logic [2:0]   m_user;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           idle_cycles = 0;

  quadratic_root_solver_core u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  quadratic_root_solver_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(negedge clk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

  always @(posedge clk) begin
    if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_coefs(input logic [15:0] a, input logic [15:0] b,
                            input logic [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= {c, b, a};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random;
    logic [15:0] a, b, c;
    a = 16'($urandom);
    b = 16'($urandom);
    c = 16'($urandom);
    case ($urandom_range(9))
      0: a = 16'(0);
      1: a = 16'($signed($urandom_range(8)) - 4);   // tiny a pushes roots out of range
      2: c = 16'($signed($urandom_range(512)) - 256);
      3: begin
        a = 16'($urandom_range(1023) - 512);
        b = 16'($urandom_range(4095) - 2048);
        c = 16'($urandom_range(1023) - 512);
      end
      default: ;
    endcase
    send_coefs(a, b, c);
  endtask

  initial begin
    rst_n = 0;
    s_valid = 0;
    s_data = '0;
    send_idle_pct = 36;
    recv_idle_pct = 53;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Degenerate, double root, real pair, complex pair and field extremes.
    send_coefs(16'h0000, 16'h1234, 16'h5678);
    send_coefs(16'h0000, 16'h0000, 16'h0000);
    send_coefs(16'h0100, 16'h0200, 16'h0100);
    send_coefs(16'h0100, 16'h0000, 16'hfc00);
    send_coefs(16'h0100, 16'h0000, 16'h0400);
    send_coefs(16'hff00, 16'h0300, 16'h0200);
    send_coefs(16'h7fff, 16'h7fff, 16'h7fff);
    send_coefs(16'h8000, 16'h8000, 16'h8000);
    send_coefs(16'h7fff, 16'h8000, 16'h7fff);
    send_coefs(16'h8000, 16'h7fff, 16'h7fff);
    send_coefs(16'h0001, 16'h8000, 16'h0000);
    send_coefs(16'h0001, 16'h7fff, 16'h7fff);
    send_coefs(16'hffff, 16'h8000, 16'h8000);
    send_coefs(16'h0001, 16'h0000, 16'h7fff);
    send_coefs(16'hffff, 16'hffff, 16'hffff);
    send_coefs(16'h0001, 16'h0001, 16'h0001);
    send_coefs(16'h0100, 16'h0000, 16'h0000);
    send_coefs(16'h0200, 16'hfa00, 16'h0400);
    send_coefs(16'h0003, 16'h0007, 16'h0002);

    for (int i = 0; i < 650; i++) begin
      if (i == 217) begin
        send_idle_pct = 53;
        recv_idle_pct = 36;
      end else if (i == 434) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_random();
    end
    s_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/qrs_pkg.sv
src/qrs_div_pipe.sv
src/quadratic_root_solver_core.sv
tb/quadratic_root_solver_checker.sv
tb/quadratic_root_solver_core_tb.sv
